@@ rtl/rmr_pkg.sv @@
package rmr_pkg;

  localparam int unsigned DEFAULT_WINDOW = 32;

  localparam logic [11:0] NAK_INITIAL_RST = 12'd40;
  localparam logic [15:0] HB_TIMEOUT_RST  = 16'd1500;
  localparam logic [15:0] ACK_INT_RST     = 16'd200;
  localparam logic [31:0] START_SEQ_RST   = 32'd1;
  localparam logic [31:0] SUB_ID_RST      = 32'd0;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NAK_INITIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_INT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_ID      = 3'd4;

  typedef enum logic [1:0] {
    OP_PKT  = 2'd0,
    OP_TICK = 2'd1,
    OP_HB   = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_NAK     = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_DRAIN,
    ST_ACK
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seq_no;
    logic [31:0] payload;
    logic [31:0] now;
  } item_t;

endpackage

@@ rtl/rmr_front.sv @@
// Front end: takes input transactions, drops unused op codes, queues the rest.
module rmr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [95:0]    s_axis_tdata_i,
  input  logic [1:0]     s_axis_tuser_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output rmr_pkg::item_t item_o
);

  rmr_pkg::item_t q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  rmr_pkg::item_t in_item;

  assign in_item.op      = rmr_pkg::op_e'(s_axis_tuser_i);
  assign in_item.seq_no  = s_axis_tdata_i[31:0];
  assign in_item.payload = s_axis_tdata_i[63:32];
  assign in_item.now     = s_axis_tdata_i[95:64];

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push = s_axis_tvalid_i && s_axis_tready_o && (in_item.op != rmr_pkg::OP_NONE);
  assign pop  = item_valid_o && item_ready_i;

  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ rtl/rmr_back.sv @@
// Back end: sequence tracking, reorder window, NAK/ACK timers, output register.
module rmr_back #(
  parameter int unsigned WINDOW = rmr_pkg::DEFAULT_WINDOW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rmr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rmr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  rmr_pkg::item_t                   item_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [95:0]                      m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  localparam int unsigned IDX_W = $clog2(WINDOW);

  // config
  logic [11:0] nak_init_q, nak_init_d;
  logic [15:0] hb_to_q, hb_to_d;
  logic [15:0] ack_int_q, ack_int_d;
  logic [31:0] start_q, start_d;
  logic [31:0] sid_q, sid_d;

  // receiver state
  rmr_pkg::state_e state_q, state_d;
  logic [31:0] exp_q, exp_d;
  logic        gap_q, gap_d;
  logic [31:0] gap_clk_q, gap_clk_d;
  logic [31:0] dlv_clk_q, dlv_clk_d;
  logic [15:0] nak_int_q, nak_int_d;
  logic [31:0] ack_clk_q, ack_clk_d;
  logic [WINDOW-1:0] valid_q, valid_d;

  logic [31:0] slot_mem [WINDOW];
  logic [31:0] rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;

  // output register
  logic         ov_q, ov_d;
  rmr_pkg::kind_e okind_q, okind_d;
  logic [31:0]  oseq_q, oseq_d;
  logic [31:0]  opay_q, opay_d;
  logic [31:0]  osid_q, osid_d;
  logic         olast_q, olast_d;

  logic             out_free;
  logic             pop;
  logic [IDX_W-1:0] exp_idx, nxt_idx, seq_idx;
  logic [31:0]      seq_ahead;
  logic             timeout, nak_fire, ack_fire;
  logic [16:0]      dbl;

  assign out_free     = !ov_q || m_axis_tready_i;
  assign item_ready_o = (state_q == rmr_pkg::ST_IDLE) && out_free;
  assign pop          = item_valid_i && item_ready_o;

  assign exp_idx   = exp_q[IDX_W-1:0];
  assign nxt_idx   = exp_idx + IDX_W'(1);
  assign seq_idx   = item_i.seq_no[IDX_W-1:0];
  assign seq_ahead = item_i.seq_no - exp_q;

  assign timeout  = (item_i.now - dlv_clk_q) > {16'd0, hb_to_q};
  assign nak_fire = gap_q && ((item_i.now - gap_clk_q) > {16'd0, nak_int_q});
  assign ack_fire = (item_i.now - ack_clk_q) > {16'd0, ack_int_q};
  assign dbl      = {nak_int_q, 1'b0};

  always_comb begin
    nak_init_d = nak_init_q;
    hb_to_d    = hb_to_q;
    ack_int_d  = ack_int_q;
    start_d    = start_q;
    sid_d      = sid_q;
    state_d    = state_q;
    exp_d      = exp_q;
    gap_d      = gap_q;
    gap_clk_d  = gap_clk_q;
    dlv_clk_d  = dlv_clk_q;
    nak_int_d  = nak_int_q;
    ack_clk_d  = ack_clk_q;
    valid_d    = valid_q;
    mem_we     = 1'b0;
    mem_wa     = seq_idx;
    ov_d       = ov_q && !m_axis_tready_i;
    okind_d    = okind_q;
    oseq_d     = oseq_q;
    opay_d     = opay_q;
    osid_d     = osid_q;
    olast_d    = olast_q;

    unique case (state_q)
      rmr_pkg::ST_IDLE: begin
        if (pop) begin
          unique case (item_i.op)
            rmr_pkg::OP_PKT: begin
              if (item_i.seq_no == exp_q) begin
                ov_d    = 1'b1;
                okind_d = rmr_pkg::KIND_DELIVER;
                oseq_d  = exp_q;
                opay_d  = item_i.payload;
                osid_d  = 32'd0;
                olast_d = !valid_q[nxt_idx];
                valid_d[exp_idx] = 1'b0;
                exp_d     = exp_q + 32'd1;
                dlv_clk_d = item_i.now;
                gap_d     = 1'b0;
                if (valid_q[nxt_idx]) begin
                  state_d = rmr_pkg::ST_RD;
                end
              end else if (item_i.seq_no > exp_q) begin
                if (!gap_q) begin
                  gap_d     = 1'b1;
                  gap_clk_d = item_i.now;
                  nak_int_d = {4'd0, nak_init_q};
                  ov_d    = 1'b1;
                  okind_d = rmr_pkg::KIND_NAK;
                  oseq_d  = exp_q - 32'd1;
                  opay_d  = 32'd0;
                  osid_d  = sid_q;
                  olast_d = 1'b1;
                end
                if (seq_ahead < 32'(WINDOW)) begin
                  mem_we           = 1'b1;
                  valid_d[seq_idx] = 1'b1;
                end
              end
            end
            rmr_pkg::OP_TICK: begin
              if (timeout && !gap_q) begin
                gap_d     = 1'b1;
                gap_clk_d = item_i.now;
                nak_int_d = {4'd0, nak_init_q};
              end
              if (nak_fire) begin
                ov_d    = 1'b1;
                okind_d = rmr_pkg::KIND_NAK;
                oseq_d  = exp_q - 32'd1;
                opay_d  = 32'd0;
                osid_d  = sid_q;
                olast_d = !ack_fire;
                gap_clk_d = item_i.now;
                if (nak_int_q < {nak_init_q, 4'd0}) begin
                  nak_int_d = dbl[16] ? 16'hFFFF : dbl[15:0];
                end
              end
              if (ack_fire) begin
                ack_clk_d = item_i.now;
                if (nak_fire) begin
                  state_d = rmr_pkg::ST_ACK;
                end else begin
                  ov_d    = 1'b1;
                  okind_d = rmr_pkg::KIND_ACK;
                  oseq_d  = exp_q - 32'd1;
                  opay_d  = 32'd0;
                  osid_d  = sid_q;
                  olast_d = 1'b1;
                end
              end
            end
            rmr_pkg::OP_HB: begin
              if (item_i.seq_no == exp_q - 32'd1) begin
                dlv_clk_d = item_i.now;
                gap_d     = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      rmr_pkg::ST_RD: begin
        state_d = rmr_pkg::ST_DRAIN;
      end
      rmr_pkg::ST_DRAIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = rmr_pkg::KIND_DELIVER;
          oseq_d  = exp_q;
          opay_d  = rdata_q;
          osid_d  = 32'd0;
          olast_d = !valid_q[nxt_idx];
          valid_d[exp_idx] = 1'b0;
          exp_d   = exp_q + 32'd1;
          state_d = valid_q[nxt_idx] ? rmr_pkg::ST_RD : rmr_pkg::ST_IDLE;
        end
      end
      rmr_pkg::ST_ACK: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = rmr_pkg::KIND_ACK;
          oseq_d  = exp_q - 32'd1;
          opay_d  = 32'd0;
          osid_d  = sid_q;
          olast_d = 1'b1;
          state_d = rmr_pkg::ST_IDLE;
        end
      end
      default: state_d = rmr_pkg::ST_IDLE;
    endcase

    // the user must write configuration only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmr_pkg::REG_NAK_INITIAL: nak_init_d = cfg_data_i[11:0];
        rmr_pkg::REG_HB_TIMEOUT:  hb_to_d    = cfg_data_i[15:0];
        rmr_pkg::REG_ACK_INT:     ack_int_d  = cfg_data_i[15:0];
        rmr_pkg::REG_START_SEQ: begin
          start_d = cfg_data_i;
          exp_d   = cfg_data_i;
          valid_d = '0;
        end
        rmr_pkg::REG_SUB_ID:      sid_d      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nak_init_q <= rmr_pkg::NAK_INITIAL_RST;
      hb_to_q    <= rmr_pkg::HB_TIMEOUT_RST;
      ack_int_q  <= rmr_pkg::ACK_INT_RST;
      start_q    <= rmr_pkg::START_SEQ_RST;
      sid_q      <= rmr_pkg::SUB_ID_RST;
      state_q    <= rmr_pkg::ST_IDLE;
      exp_q      <= rmr_pkg::START_SEQ_RST;
      gap_q      <= 1'b0;
      gap_clk_q  <= 32'd0;
      dlv_clk_q  <= 32'd0;
      nak_int_q  <= {4'd0, rmr_pkg::NAK_INITIAL_RST};
      ack_clk_q  <= 32'd0;
      valid_q    <= '0;
      ov_q       <= 1'b0;
    end else begin
      nak_init_q <= nak_init_d;
      hb_to_q    <= hb_to_d;
      ack_int_q  <= ack_int_d;
      start_q    <= start_d;
      sid_q      <= sid_d;
      state_q    <= state_d;
      exp_q      <= exp_d;
      gap_q      <= gap_d;
      gap_clk_q  <= gap_clk_d;
      dlv_clk_q  <= dlv_clk_d;
      nak_int_q  <= nak_int_d;
      ack_clk_q  <= ack_clk_d;
      valid_q    <= valid_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oseq_q  <= oseq_d;
    opay_q  <= opay_d;
    osid_q  <= osid_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= item_i.payload;
    end
    rdata_q <= slot_mem[exp_idx];
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {osid_q, opay_q, oseq_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

@@ rtl/reliable_multicast_receiver_reorder_core.sv @@
// Order: an input transaction is registered in a queue entry, then the back end takes it
// and registers its first result in the output register, from which it can be taken.
// Throughput: one input transaction per cycle into a two-entry queue while it is not full;
// the back end takes one item per cycle while idle with its output free; each further in-order
// packet from the window takes a slot read state, then output; a NAK-and-ACK tick emits the ACK last.
// Reset (rst_ni, asynchronous, active low) restores register defaults and clears the window.
module reliable_multicast_receiver_reorder_core #(
  // window depth, a power of two; slot = low bits of the sequence number
  parameter int unsigned WINDOW = rmr_pkg::DEFAULT_WINDOW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port, index = register number
  input  logic                           cfg_we_i,
  input  logic [rmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input events
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [95:0]                    s_axis_tdata_i,  // seq_no, payload, now
  input  logic [1:0]                     s_axis_tuser_i,  // op
  // results
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [95:0]                    m_axis_tdata_o,  // seq_no_res, payload_res, subscriber_id_res
  output logic [1:0]                     m_axis_tuser_o,  // kind
  output logic                           m_axis_tlast_o   // last result of the transaction
);

  logic           item_valid;
  logic           item_ready;
  rmr_pkg::item_t item;

  // front: decode op, drop the unused code, queue for the back end
  rmr_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // back: sequencing, window store and drain, timers, output register
  rmr_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

endmodule

@@ rtl/rmr_checker.sv @@
module rmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("bad result kind");

  a_dlv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == rmr_pkg::KIND_DELIVER |-> m_axis_tdata_o[95:64] == 32'd0)
    else $error("delivery carries subscriber id");

  a_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != rmr_pkg::KIND_DELIVER |-> m_axis_tdata_o[63:32] == 32'd0)
    else $error("NAK/ACK carries payload");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == rmr_pkg::KIND_ACK |-> m_axis_tlast_o)
    else $error("ACK not last");

endmodule

bind reliable_multicast_receiver_reorder_core rmr_checker u_rmr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Scoreboard: mirrors receiver state, queues expected results and checks them in order.
class rmr_scoreboard;
  localparam int unsigned WIN = rmr_pkg::DEFAULT_WINDOW;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [31:0] data;
    logic [31:0] sid;
    logic        last;
  } res_t;

  // registers
  logic [11:0] nak_init;
  logic [15:0] hb_tmo;
  logic [15:0] ack_int;
  logic [31:0] start_seq;
  logic [31:0] sub_id;
  // receiver state
  logic [31:0] exp_seq;
  bit          gap_on;
  logic [31:0] gap_clk;
  logic [31:0] dlv_clk;
  logic [31:0] nak_ivl;
  logic [31:0] ack_clk;
  bit          slot_vld [WIN];
  logic [31:0] slot_data [WIN];

  res_t pending_res[$];
  int   err_cnt;

  function new();
    nak_init  = rmr_pkg::NAK_INITIAL_RST;
    hb_tmo    = rmr_pkg::HB_TIMEOUT_RST;
    ack_int   = rmr_pkg::ACK_INT_RST;
    start_seq = rmr_pkg::START_SEQ_RST;
    sub_id    = rmr_pkg::SUB_ID_RST;
    exp_seq   = start_seq;
    gap_on    = 0;
    gap_clk   = 0;
    dlv_clk   = 0;
    nak_ivl   = nak_init;
    ack_clk   = 0;
    foreach (slot_vld[i]) slot_vld[i] = 0;
    err_cnt   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      rmr_pkg::REG_NAK_INITIAL: nak_init = val[11:0];
      rmr_pkg::REG_HB_TIMEOUT:  hb_tmo = val[15:0];
      rmr_pkg::REG_ACK_INT:     ack_int = val[15:0];
      rmr_pkg::REG_START_SEQ: begin
        start_seq = val;
        exp_seq = val;
        foreach (slot_vld[i]) slot_vld[i] = 0;
      end
      rmr_pkg::REG_SUB_ID:      sub_id = val;
      default: ;
    endcase
  endfunction

  function void push(rmr_pkg::kind_e k, logic [31:0] s, logic [31:0] d, logic [31:0] id);
    res_t r;
    r.kind = k;
    r.seq  = s;
    r.data = d;
    r.sid  = id;
    r.last = 0;
    pending_res.push_back(r);
  endfunction

  // note one accepted input transaction
  function void note_event(rmr_pkg::op_e op, logic [31:0] seq, logic [31:0] data,
                           logic [31:0] now);
    int n;
    logic [31:0] seq_ahead;
    n = 0;
    case (op)
      rmr_pkg::OP_PKT: begin
        if (seq < exp_seq) return;
        if (seq != exp_seq) begin
          seq_ahead = seq - exp_seq;
          if (!gap_on) begin
            gap_on = 1;
            gap_clk = now;
            nak_ivl = nak_init;
            push(rmr_pkg::KIND_NAK, exp_seq - 1, 0, sub_id);
            n++;
          end
          if (seq_ahead < WIN) begin
            slot_vld[seq % WIN] = 1;
            slot_data[seq % WIN] = data;
          end
        end else begin
          push(rmr_pkg::KIND_DELIVER, exp_seq, data, 0);
          n++;
          slot_vld[exp_seq % WIN] = 0;
          exp_seq++;
          while (n < WIN && slot_vld[exp_seq % WIN]) begin
            push(rmr_pkg::KIND_DELIVER, exp_seq, slot_data[exp_seq % WIN], 0);
            n++;
            slot_vld[exp_seq % WIN] = 0;
            exp_seq++;
          end
          dlv_clk = now;
          gap_on = 0;
        end
      end
      rmr_pkg::OP_TICK: begin
        if (32'(now - dlv_clk) > hb_tmo && !gap_on) begin
          gap_on = 1;
          gap_clk = now;
          nak_ivl = nak_init;
        end
        if (gap_on && 32'(now - gap_clk) > nak_ivl) begin
          push(rmr_pkg::KIND_NAK, exp_seq - 1, 0, sub_id);
          n++;
          gap_clk = now;
          if (nak_ivl < 16 * nak_init) begin
            nak_ivl = nak_ivl * 2;
            if (nak_ivl > 32'hFFFF) nak_ivl = 32'hFFFF;
          end
        end
        if (32'(now - ack_clk) > ack_int) begin
          push(rmr_pkg::KIND_ACK, exp_seq - 1, 0, sub_id);
          n++;
          ack_clk = now;
        end
      end
      rmr_pkg::OP_HB: begin
        if (seq == exp_seq - 1) begin
          dlv_clk = now;
          gap_on = 0;
        end
      end
      default: ;
    endcase
    if (n > 0) pending_res[$].last = 1;
  endfunction

  task report(string what);
    $display("mismatch @%0t: %s", $time, what);
    err_cnt++;
  endtask

  task check_result(logic [1:0] kind, logic [95:0] tdata, logic last);
    res_t e;
    if (pending_res.size() == 0) begin
      report($sformatf("unexpected result kind %0d tdata %h", kind, tdata));
      return;
    end
    e = pending_res.pop_front();
    if (kind !== e.kind) report($sformatf("kind %0d, want %0d", kind, e.kind));
    if (tdata[31:0] !== e.seq) report($sformatf("seq %h, want %h", tdata[31:0], e.seq));
    if (tdata[63:32] !== e.data)
      report($sformatf("payload %h, want %h", tdata[63:32], e.data));
    if (tdata[95:64] !== e.sid) report($sformatf("sub id %h, want %h", tdata[95:64], e.sid));
    if (last !== e.last) report($sformatf("tlast %b, want %b", last, e.last));
  endtask
endclass

module testbench;

  localparam int unsigned WIN      = rmr_pkg::DEFAULT_WINDOW;
  localparam int unsigned WD_LIMIT = 5000;  // idle cycles before giving up

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;  // seq_no, payload, now
  logic [1:0]  s_axis_tuser_i = '0;  // op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [95:0] m_axis_tdata_o;       // seq_no_res, payload_res, subscriber_id_res
  logic [1:0]  m_axis_tuser_o;       // kind
  logic        m_axis_tlast_o;

  rmr_scoreboard sb;

  // idling per cent for sender and receiver, changed per phase
  int          src_idle = 0;
  int          snk_stall = 0;
  int          wd_cnt = 0;
  logic [31:0] clk_ms = 0;   // stimulus wall clock, used as the now field of events

  always #5 clk_i = ~clk_i;

  reliable_multicast_receiver_reorder_core DUT (.*);

  // output side: sample at the rising edge, randomise tready at the falling one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_stall);
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      wd_cnt <= 0;
    else if (rst_ni)
      wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one input transaction; gaps are inserted before it at the current idle rate.
  // tvalid stays high after the transaction so back-to-back items need no gap.
  task automatic send_event(rmr_pkg::op_e op, logic [31:0] seq, logic [31:0] data,
                            logic [31:0] now);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {now, data, seq};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_event(op, seq, data, now);
    @(negedge clk_i);
  endtask

  // wait for all outstanding results, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (sb.pending_res.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic pkt(logic [31:0] seq);
    clk_ms += $urandom_range(20);
    send_event(rmr_pkg::OP_PKT, seq, $urandom(), clk_ms);
  endtask

  task automatic tick(int step);
    clk_ms += step;
    send_event(rmr_pkg::OP_TICK, $urandom(), $urandom(), clk_ms);
  endtask

  // mostly in-window traffic around the expected number, plus ticks and heartbeats
  task automatic random_events(int count);
    int          r;
    logic [31:0] base;
    for (int i = 0; i < count; i++) begin
      base = sb.exp_seq;
      r = $urandom_range(99);
      if (r < 45) pkt(base + $urandom_range(WIN + 3));
      else if (r < 55) pkt(base);
      else if (r < 60) pkt(base - $urandom_range(1, 5));
      else if (r < 63) pkt($urandom());
      else if (r < 85) tick($urandom_range(3) == 0 ? $urandom_range(5000) : $urandom_range(300));
      else if (r < 93) begin
        clk_ms += $urandom_range(50);
        send_event(rmr_pkg::OP_HB, ($urandom_range(1) ? base - 1 : $urandom()), $urandom(),
                   clk_ms);
      end else if (r < 97) begin
        clk_ms = $urandom();
        send_event(rmr_pkg::OP_TICK, $urandom(), $urandom(), clk_ms);
      end else
        send_event(rmr_pkg::OP_NONE, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: in-order, reorder drain, full window drain, beyond window, extremes
    pkt(1);
    pkt(3);
    pkt(4);
    pkt(2);
    for (int s = 6; s < 6 + WIN - 1; s++) pkt(s);
    pkt(5);
    pkt(sb.exp_seq + WIN);
    pkt(sb.exp_seq + 7);
    pkt(sb.exp_seq + 7);  // duplicate overwrites
    pkt(sb.exp_seq);
    pkt(0);
    tick(100);
    tick(2000);
    tick(10);
    tick(100);
    send_event(rmr_pkg::OP_HB, sb.exp_seq - 1, 32'hFFFF_FFFF, clk_ms);
    send_event(rmr_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pkt(32'hFFFF_FFFF);
    drain();  // sender holds off until everything has come back

    // configuration phases: extremes and a zero nak_initial
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 66; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 66; end
        3: begin src_idle = 16; snk_stall = 16; end
        default: begin src_idle = 0; snk_stall = 0; end
      endcase
      write_cfg(rmr_pkg::REG_NAK_INITIAL,
                ph == 4 ? 32'd0 : (ph == 1 ? 32'd4095 : $urandom_range(1, 200)));
      write_cfg(rmr_pkg::REG_HB_TIMEOUT,
                ph == 2 ? 32'd65535 : (ph == 3 ? 32'd1 : $urandom_range(1, 3000)));
      write_cfg(rmr_pkg::REG_ACK_INT,
                ph == 1 ? 32'd65535 : (ph == 2 ? 32'd1 : $urandom_range(1, 400)));
      write_cfg(rmr_pkg::REG_START_SEQ,
                ph == 3 ? 32'hFFFF_FFD0 : (ph == 0 ? 32'd0 : $urandom()));
      write_cfg(rmr_pkg::REG_SUB_ID, ph == 0 ? 32'hFFFF_FFFF : $urandom());
      random_events(85);
    end

    drain();
    if (sb.err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
